### rtl/priority_schedule_times_assert.svh
// Assertion macros shared by the priority scheduler checker.
`ifndef PRIORITY_SCHEDULE_TIMES_ASSERT_SVH
`define PRIORITY_SCHEDULE_TIMES_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSCHED_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PSCHED_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/psched_pkg.sv
// Shared types and constants of the priority scheduler.
package psched_pkg;

    localparam int MAX_PROCS = 16;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 20;
    localparam int SUM_W   = 24;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 96;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_job;

    // Controller to datapath
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_left;
    } t_status;

endpackage

### rtl/psched_ctrl.sv
// Load/drain controller of the priority scheduler.
module psched_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    input  logic                i_s_axis_tlast,
    output logic                o_s_axis_tready,
    input  psched_pkg::t_status i_sts,
    output psched_pkg::t_cmd    o_cmd
);
    import psched_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_s_axis_tvalid && i_s_axis_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // return once the final job has left the chain
                if (i_sts.out_free && i_sts.last_left) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        case (r_state)
            ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                o_cmd.ins       = i_s_axis_tvalid;
            end
            ST_DRAIN: begin
                o_cmd.pop = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### rtl/psched_dp.sv
// Insertion chain, timing accumulators and result register of the scheduler.
module psched_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psched_pkg::t_cmd                    i_cmd,
    output psched_pkg::t_status                 o_sts,
    input  logic [psched_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                                i_m_axis_tready,
    output logic                                o_m_axis_tvalid,
    output logic [psched_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import psched_pkg::*;

    t_job                   w_in;
    t_job                   r_job [MAX_PROCS];
    logic [MAX_PROCS-1:0]   r_vld;
    logic [MAX_PROCS-1:0]   w_move;
    logic                   w_full;

    logic [TIME_W-1:0]      r_clk;
    logic [SUM_W-1:0]       r_tat;
    logic [SUM_W-1:0]       r_tws;
    logic [TIME_W-1:0]      w_done;

    logic                   r_o_valid;
    logic [ID_W-1:0]        r_o_id;
    logic [TIME_W-1:0]      r_o_done;
    logic [TIME_W-1:0]      r_o_wait;
    logic [SUM_W-1:0]       r_o_tat;
    logic [SUM_W-1:0]       r_o_tws;
    logic                   r_o_final;

    assign w_in.id    = i_s_axis_tdata[ID_W-1:0];
    assign w_in.burst = i_s_axis_tdata[ID_W +: BURST_W];
    assign w_in.prio  = i_s_axis_tdata[ID_W+BURST_W +: PRIO_W];

    assign w_full = r_vld[MAX_PROCS-1];

    // A cell moves when it is empty or holds a strictly larger priority value;
    // equal values stay ahead, which keeps arrival order among ties.
    always_comb begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            w_move[i] = !r_vld[i] || (r_job[i].prio > w_in.prio);
        end
    end

    for (genvar gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
        t_job w_prev_job;
        logic w_prev_move;
        logic w_prev_vld;
        t_job w_next_job;
        logic w_next_vld;

        if (gi == 0) begin : g_head
            assign w_prev_job  = w_in;
            assign w_prev_move = 1'b0;
            assign w_prev_vld  = 1'b1;
        end else begin : g_body
            assign w_prev_job  = r_job[gi-1];
            assign w_prev_move = w_move[gi-1];
            assign w_prev_vld  = r_vld[gi-1];
        end

        if (gi == MAX_PROCS - 1) begin : g_tail
            assign w_next_job = r_job[gi];
            assign w_next_vld = 1'b0;
        end else begin : g_mid
            assign w_next_job = r_job[gi+1];
            assign w_next_vld = r_vld[gi+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (i_cmd.ins && !w_full && w_move[gi]) begin
                r_vld[gi] <= w_prev_move ? w_prev_vld : 1'b1;
            end else if (i_cmd.pop) begin
                r_vld[gi] <= w_next_vld;
            end
        end

        // shift down behind the insertion point, take the new job at it
        always_ff @(posedge i_clk) begin
            if (i_cmd.ins && !w_full && w_move[gi]) begin
                r_job[gi] <= w_prev_move ? w_prev_job : w_in;
            end else if (i_cmd.pop) begin
                r_job[gi] <= w_next_job;
            end
        end
    end

    assign w_done = r_clk + TIME_W'(r_job[0].burst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk <= '0;
            r_tat <= '0;
            r_tws <= '0;
        end else if (i_cmd.pop) begin
            if (!r_vld[1]) begin
                // schedule finished: start the next set from zero
                r_clk <= '0;
                r_tat <= '0;
                r_tws <= '0;
            end else begin
                r_clk <= w_done;
                r_tat <= r_tat + SUM_W'(w_done);
                r_tws <= r_tws + SUM_W'(r_clk);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_o_id    <= r_job[0].id;
            r_o_done  <= w_done;
            r_o_wait  <= r_clk;
            r_o_tat   <= r_tat + SUM_W'(w_done);
            r_o_tws   <= r_tws + SUM_W'(r_clk);
            r_o_final <= !r_vld[1];
        end
    end

    assign o_sts.out_free  = !r_o_valid || i_m_axis_tready;
    assign o_sts.last_left = !r_vld[1];

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_tws, r_o_tat, r_o_wait, r_o_done, r_o_id};
    assign o_m_axis_tlast  = r_o_final;

endmodule

### rtl/priority_schedule_times.sv
// Non-preemptive priority scheduler: top level.
//
// Slave channel: one job per transaction, tdata = {prio, burst, id}, tlast on
// the final job of a set. Jobs enter an insertion chain kept in ascending
// priority order (ties in arrival order), one per cycle. Jobs beyond the
// chain depth are dropped; their tlast still closes the set.
// After the tlast transaction tready falls and the chain drains from its head,
// one result per cycle into the output register while it is free. The first
// result is loaded once the state register is in drain and the output
// register is free. Each result carries completion and waiting times and the
// running totals; tlast marks the last job.
// Throughput: one job per cycle while loading, one result per cycle while
// draining with the output register free; the chain's single insert/shift
// path sets both. tready rises as the final result is loaded, even if it waits.
// Stalls: a receiver holding tready low freezes the output register and the
// drain; nothing is lost.
// Reset (synchronous, active low) empties the chain, clears the totals and
// drops any pending result.
module priority_schedule_times (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] job_id, [23:8] burst_time, [31:24] priority_req
    input  logic [psched_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] out_job_id, [27:8] completion, [47:28] waiting_time,
    // [71:48] total_turnaround, [95:72] total_waiting
    output logic [psched_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import psched_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    psched_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    psched_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

### rtl/psched_chk.sv
// Port-level checker of the priority scheduler, bound to the top level.
`include "priority_schedule_times_assert.svh"

module psched_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                i_s_axis_tlast,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [psched_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    input logic                                o_m_axis_tlast
);
    import psched_pkg::*;

    // hold a stalled result
    `PSCHED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")

    // closing a set stops loading
    `PSCHED_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, !o_s_axis_tready, "input still open after last job")

    // no loading while a schedule is still being delivered
    `PSCHED_ASSERT_NOW(a_no_load_mid, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready, "input open during drain")

    // a taken non-final result is followed straight away by the next one
    `PSCHED_ASSERT_NEXT(a_drain_cont, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid, "gap in result stream")

endmodule

bind priority_schedule_times psched_chk u_psched_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### bench/tb.sv
// Self-checking bench for the priority scheduler: job sets in, timing results checked.
`timescale 1ns / 100ps

module tb;
    import psched_pkg::*;

    localparam int IDLE_PCT   = 13;
    localparam int STALL_MAX  = 5000;
    localparam int TAIL_WAIT  = 40;
    localparam int RAND_ITEMS = 470;

    typedef struct {
        t_job job;
        logic last;
        logic hold;
    } t_feed;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] done;
        logic [TIME_W-1:0] wait_t;
        logic [SUM_W-1:0]  tat_sum;
        logic [SUM_W-1:0]  wait_sum;
        logic              fin;
    } t_timing;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic                 i_s_axis_tlast = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    t_feed   job_feed[$];
    t_job    held_jobs[$];
    t_timing timing_due[$];
    t_feed   on_bus;

    int n_loaded = 0;
    int n_sets = 0;
    int n_dropped = 0;
    int n_results = 0;
    int n_errors = 0;
    int stall_cycles = 0;

    priority_schedule_times DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Order the held jobs by priority (ties in arrival order) and queue their timings.
    task automatic release_set();
        t_job            ordered[$];
        t_timing         r;
        int              p;
        logic [TIME_W-1:0] clock_t;
        logic [SUM_W-1:0]  tat_acc;
        logic [SUM_W-1:0]  wait_acc;
        clock_t  = '0;
        tat_acc  = '0;
        wait_acc = '0;
        foreach (held_jobs[i]) begin
            p = ordered.size();
            while (p > 0 && ordered[p-1].prio > held_jobs[i].prio)
                p--;
            ordered.insert(p, held_jobs[i]);
        end
        foreach (ordered[k]) begin
            clock_t    = clock_t + TIME_W'(ordered[k].burst);
            r.id       = ordered[k].id;
            r.done     = clock_t;
            r.wait_t   = clock_t - TIME_W'(ordered[k].burst);
            tat_acc    = tat_acc + SUM_W'(r.done);
            wait_acc   = wait_acc + SUM_W'(r.wait_t);
            r.tat_sum  = tat_acc;
            r.wait_sum = wait_acc;
            r.fin      = (k == ordered.size() - 1);
            timing_due.insert(timing_due.size(), r);
        end
        held_jobs = {};
        n_sets++;
    endtask

    task automatic load_job(input t_feed f);
        if (held_jobs.size() < MAX_PROCS)
            held_jobs.insert(held_jobs.size(), f.job);
        else
            n_dropped++;
        if (f.last)
            release_set();
    endtask

    task automatic note_mismatch(input string what, input logic [SUM_W-1:0] exp_v,
                                 input logic [SUM_W-1:0] got_v);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     n_results, what, exp_v, got_v);
    endtask

    // Driver: present queued jobs, hold on a stall, idle at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                load_job(on_bus);
                n_loaded++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (job_feed.size() > 0 && !(job_feed[0].hold && timing_due.size() > 0) &&
                    ((n_loaded >= 200 && n_loaded < 300) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    on_bus = job_feed.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {on_bus.job.prio, on_bus.job.burst, on_bus.job.id};
                    i_s_axis_tlast  <= on_bus.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expected timing.
    always @(posedge i_clk) begin
        t_timing want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (timing_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: job %0d", o_m_axis_tdata[7:0]);
                end else begin
                    want = timing_due.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.id)
                        note_mismatch("job id", SUM_W'(want.id), SUM_W'(o_m_axis_tdata[7:0]));
                    if (o_m_axis_tdata[27:8] !== want.done)
                        note_mismatch("completion", SUM_W'(want.done),
                                      SUM_W'(o_m_axis_tdata[27:8]));
                    if (o_m_axis_tdata[47:28] !== want.wait_t)
                        note_mismatch("waiting", SUM_W'(want.wait_t),
                                      SUM_W'(o_m_axis_tdata[47:28]));
                    if (o_m_axis_tdata[71:48] !== want.tat_sum)
                        note_mismatch("total turnaround", want.tat_sum, o_m_axis_tdata[71:48]);
                    if (o_m_axis_tdata[95:72] !== want.wait_sum)
                        note_mismatch("total waiting", want.wait_sum, o_m_axis_tdata[95:72]);
                    if (o_m_axis_tlast !== want.fin)
                        note_mismatch("final flag", SUM_W'(want.fin), SUM_W'(o_m_axis_tlast));
                end
                n_results++;
            end
            i_m_axis_tready <= (n_results >= 200 && n_results < 300) ||
                               ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: give up when nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("timeout after %0d idle cycles", stall_cycles);
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic add_job(input logic [7:0] id, input logic [15:0] burst,
                           input logic [7:0] prio, input logic last, input logic hold);
        t_feed f;
        f.job.id    = id;
        f.job.burst = burst;
        f.job.prio  = prio;
        f.last      = last;
        f.hold      = hold;
        job_feed.insert(job_feed.size(), f);
    endtask

    initial begin
        int total;
        int set_len;
        int prio_top;
        logic [15:0] burst;

        // Single job at the top of every field.
        add_job(8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
        // Full set of longest bursts, then two dropped jobs; the last of them closes the set.
        for (int i = 0; i < 18; i++)
            add_job(8'(i * 15), 16'hFFFF, (i == 3) ? 8'd0 : 8'(255 - (i % 4)),
                    i == 17, 1'b0);
        // Zero bursts, tied priorities at both ends.
        add_job(8'h00, 16'h0000, 8'hFF, 1'b0, 1'b0);
        add_job(8'h01, 16'h0001, 8'h00, 1'b0, 1'b0);
        add_job(8'h02, 16'h0000, 8'hFF, 1'b0, 1'b0);
        add_job(8'h03, 16'h8000, 8'h00, 1'b0, 1'b0);
        add_job(8'h04, 16'h7FFF, 8'h80, 1'b1, 1'b0);

        total = 0;
        while (total < RAND_ITEMS) begin
            set_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4)
                                                   : $urandom_range(1, MAX_PROCS);
            prio_top = $urandom_range(0, 1) ? 3 : 255;
            for (int i = 0; i < set_len; i++) begin
                case ($urandom_range(0, 9))
                    0:       burst = 16'h0000;
                    1:       burst = 16'hFFFF;
                    default: burst = 16'($urandom);
                endcase
                // Hold one set back until the previous schedule has fully drained.
                add_job(8'($urandom), burst, 8'($urandom_range(0, prio_top)),
                        i == set_len - 1,
                        (total <= 120 && total + set_len > 120) && i == 0);
            end
            total += set_len;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_feed.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        while (timing_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (timing_due.size() != 0)
            n_errors++;
        $display("covered %0d jobs in %0d sets, %0d dropped at capacity, %0d results checked",
                 n_loaded, n_sets, n_dropped, n_results);
        $display("%0d errors", n_errors);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
